// ===== hdl/isdc_pkg.sv =====
package isdc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned InDataW = 72;
  localparam int unsigned OutDataW = 16;

  // register indexes on the write port
  localparam logic [CfgIdxW-1:0] REG_SLEEP_INHIBIT     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BOOT_TIME         = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SUPPLY_TIMEOUT    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INACTIVITY_TIMEOUT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_GLITCH_WINDOW     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_GHOST_TIMEOUT     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_CLIENT_GRACE      = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_REQUEST_TIMEOUT   = 3'd7;

  // reset values of the timing registers
  localparam logic [TimeW-1:0] SUPPLY_TIMEOUT_RST     = 32'd300000;
  localparam logic [TimeW-1:0] INACTIVITY_TIMEOUT_RST = 32'd600000;
  localparam logic [TimeW-1:0] GLITCH_WINDOW_RST      = 32'd15000;
  localparam logic [TimeW-1:0] GHOST_TIMEOUT_RST      = 32'd180000;
  localparam logic [TimeW-1:0] CLIENT_GRACE_RST       = 32'd30000;
  localparam logic [TimeW-1:0] REQUEST_TIMEOUT_RST    = 32'd120000;

  typedef enum logic [2:0] {
    ST_AWAKE    = 3'd0,
    ST_REAL     = 3'd1,
    ST_GHOST    = 3'd2,
    ST_GRACE    = 3'd3,
    ST_PENDING  = 3'd4,
    ST_ENTERING = 3'd5,
    ST_INACTIVE = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_SUPPLY = 2'd1,
    CAUSE_MOTION = 2'd2
  } cause_t;

  typedef struct packed {
    logic    enter_sleep;
    logic    request_cancelled;
    logic    request_raised;
    logic    request_flag;
    cause_t  sleep_cause;
    status_t status;
  } result_t;

endpackage

// ===== hdl/idle_sleep_decision_controller.sv =====
// an input transfer loads the input register; the result register drives m_tvalid
// throughput: one poll per cycle while m_tready does not stall; the input register
//   feeds one pass of compare logic that updates the sleep state and loads the
//   result register in the same cycle
// reset (rst, synchronous, active high): timing registers return to their defaults,
//   sleep state clears, both pipeline registers go empty
module idle_sleep_decision_controller (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [isdc_pkg::CfgIdxW-1:0] cfg_addr,
  input  logic [isdc_pkg::TimeW-1:0]   cfg_wdata,
  // poll stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // now_ms[31:0], supply_present[32], motion_sensor_ok[33], last_motion_ms[65:34],
  // station_attached[66], session_active[67], zero pad [71:68]
  input  logic [isdc_pkg::InDataW-1:0] s_tdata,
  // action[0]: 0 periodic poll, 1 force sleep
  input  logic        s_tuser,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], sleep_cause[4:3], request_flag[5], request_raised[6],
  // request_cancelled[7], enter_sleep[8], zero pad [15:9]
  output logic [isdc_pkg::OutDataW-1:0] m_tdata
);

  localparam int unsigned TW = isdc_pkg::TimeW;

  // configuration registers
  logic          sleep_inhibit;
  logic [TW-1:0] boot_time_ms;
  logic [TW-1:0] supply_timeout_ms;
  logic [TW-1:0] inactivity_timeout_ms;
  logic [TW-1:0] glitch_window_ms;
  logic [TW-1:0] ghost_timeout_ms;
  logic [TW-1:0] client_grace_ms;
  logic [TW-1:0] request_timeout_ms;

  // decision state
  logic          shut_down, shut_down_next;
  logic          request_pending, request_pending_next;
  logic [TW-1:0] request_time, request_time_next;
  logic [TW-1:0] last_supply_seen, last_supply_seen_next;
  logic [TW-1:0] last_real_client, last_real_client_next;
  logic [TW-1:0] ghost_start, ghost_start_next;

  // input register
  logic          in_valid;
  logic          in_force;
  logic [TW-1:0] in_now;
  logic          in_supply;
  logic          in_motion_ok;
  logic [TW-1:0] in_last_motion;
  logic          in_station;
  logic          in_session;

  // result register
  logic              out_valid;
  isdc_pkg::result_t out_res, res_next;

  logic advance;
  logic fire;

  // result register empties or is taken; input register moves on in the same cycle
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign fire     = in_valid && advance;

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(isdc_pkg::OutDataW - $bits(isdc_pkg::result_t)){1'b0}}, out_res};

  always_ff @(posedge clk) begin
    if (rst) begin
      sleep_inhibit         <= 1'b0;
      boot_time_ms          <= '0;
      supply_timeout_ms     <= isdc_pkg::SUPPLY_TIMEOUT_RST;
      inactivity_timeout_ms <= isdc_pkg::INACTIVITY_TIMEOUT_RST;
      glitch_window_ms      <= isdc_pkg::GLITCH_WINDOW_RST;
      ghost_timeout_ms      <= isdc_pkg::GHOST_TIMEOUT_RST;
      client_grace_ms       <= isdc_pkg::CLIENT_GRACE_RST;
      request_timeout_ms    <= isdc_pkg::REQUEST_TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        isdc_pkg::REG_SLEEP_INHIBIT:      sleep_inhibit         <= cfg_wdata[0];
        isdc_pkg::REG_BOOT_TIME:          boot_time_ms          <= cfg_wdata;
        isdc_pkg::REG_SUPPLY_TIMEOUT:     supply_timeout_ms     <= cfg_wdata;
        isdc_pkg::REG_INACTIVITY_TIMEOUT: inactivity_timeout_ms <= cfg_wdata;
        isdc_pkg::REG_GLITCH_WINDOW:      glitch_window_ms      <= cfg_wdata;
        isdc_pkg::REG_GHOST_TIMEOUT:      ghost_timeout_ms      <= cfg_wdata;
        isdc_pkg::REG_CLIENT_GRACE:       client_grace_ms       <= cfg_wdata;
        isdc_pkg::REG_REQUEST_TIMEOUT:    request_timeout_ms    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register: a transfer loads the payload, a pass empties it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_force       <= s_tuser;
      in_now         <= s_tdata[31:0];
      in_supply      <= s_tdata[32];
      in_motion_ok   <= s_tdata[33];
      in_last_motion <= s_tdata[65:34];
      in_station     <= s_tdata[66];
      in_session     <= s_tdata[67];
    end
  end

  // decision logic, all time differences wrap at 32 bits
  logic [TW-1:0] gone;
  logic [TW-1:0] idle_start;
  logic [TW-1:0] ghost_eff;
  logic          supply_due;
  logic          motion_due;
  isdc_pkg::cause_t cause;

  always_comb begin
    gone       = in_now - last_supply_seen;
    supply_due = gone >= supply_timeout_ms;
    idle_start = (in_last_motion != '0) ? in_last_motion : boot_time_ms;
    // motion inactivity only once the supply has been gone past the glitch window,
    // and never when the idle start lies ahead of now
    motion_due = !supply_due && (gone >= glitch_window_ms) && in_motion_ok &&
                 (idle_start <= in_now) &&
                 ((in_now - idle_start) >= inactivity_timeout_ms);
    cause      = supply_due ? isdc_pkg::CAUSE_SUPPLY : isdc_pkg::CAUSE_MOTION;
    ghost_eff  = (ghost_start == '0) ? in_now : ghost_start;

    shut_down_next        = shut_down;
    request_pending_next  = request_pending;
    request_time_next     = request_time;
    last_supply_seen_next = last_supply_seen;
    last_real_client_next = last_real_client;
    ghost_start_next      = ghost_start;

    res_next.status            = isdc_pkg::ST_AWAKE;
    res_next.sleep_cause       = isdc_pkg::CAUSE_NONE;
    res_next.request_raised    = 1'b0;
    res_next.request_cancelled = 1'b0;
    res_next.enter_sleep       = 1'b0;

    if (in_force) begin
      // force wins over inhibit and an earlier shutdown
      shut_down_next       = 1'b1;
      res_next.status      = isdc_pkg::ST_ENTERING;
      res_next.enter_sleep = 1'b1;
    end else if (sleep_inhibit || shut_down) begin
      res_next.status = isdc_pkg::ST_INACTIVE;
    end else if (in_supply) begin
      res_next.request_cancelled = request_pending;
      last_supply_seen_next      = in_now;
      request_pending_next       = 1'b0;
    end else if (supply_due || motion_due) begin
      res_next.sleep_cause = cause;
      if (in_station && in_session) begin
        last_real_client_next = in_now;
        ghost_start_next      = '0;
        res_next.status       = isdc_pkg::ST_REAL;
      end else begin
        if (in_station) begin
          ghost_start_next = ghost_eff;
        end else begin
          ghost_start_next = '0;
        end
        if (in_station && ((in_now - ghost_eff) < ghost_timeout_ms)) begin
          res_next.status = isdc_pkg::ST_GHOST;
        end else if ((last_real_client != '0) &&
                     ((in_now - last_real_client) < client_grace_ms)) begin
          res_next.status = isdc_pkg::ST_GRACE;
        end else if (!request_pending) begin
          request_pending_next    = 1'b1;
          request_time_next       = in_now;
          res_next.status         = isdc_pkg::ST_PENDING;
          res_next.request_raised = 1'b1;
        end else if ((in_now - request_time) >= request_timeout_ms) begin
          // request stays pending on the way into sleep
          shut_down_next       = 1'b1;
          res_next.status      = isdc_pkg::ST_ENTERING;
          res_next.enter_sleep = 1'b1;
        end else begin
          res_next.status = isdc_pkg::ST_PENDING;
        end
      end
    end

    res_next.request_flag = request_pending_next;
  end

  // state commits together with the result register load
  always_ff @(posedge clk) begin
    if (rst) begin
      shut_down        <= 1'b0;
      request_pending  <= 1'b0;
      request_time     <= '0;
      last_supply_seen <= '0;
      last_real_client <= '0;
      ghost_start      <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (fire) begin
        shut_down        <= shut_down_next;
        request_pending  <= request_pending_next;
        request_time     <= request_time_next;
        last_supply_seen <= last_supply_seen_next;
        last_real_client <= last_real_client_next;
        ghost_start      <= ghost_start_next;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res_next;
    end
  end

`ifndef SYNTHESIS
  // a shown sleep entry has already latched the shutdown
  a_enter_latched: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.enter_sleep) |-> shut_down)
    else $error("enter_sleep shown without shutdown latched");

  // sleep entry only ever reports the entering status
  a_enter_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.enter_sleep) |-> (out_res.status == isdc_pkg::ST_ENTERING))
    else $error("enter_sleep with wrong status");

  // a newly raised request leaves the request flag set
  a_raise_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.request_raised) |-> (out_res.request_flag && request_pending))
    else $error("request raised but flag clear");

  // a cancel only comes with supply back, so the flag is clear
  a_cancel_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.request_cancelled) |-> !out_res.request_flag)
    else $error("request cancelled but flag set");
`endif

endmodule
